/* hdl/elimination_tree_builder_assert.svh */
// Assertion macros for the checker file of the elimination tree builder.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ELIMINATION_TREE_BUILDER_ASSERT_SVH
`define ELIMINATION_TREE_BUILDER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define ETB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define ETB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must hold in the cycle after reset is applied
`define ETB_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

/* hdl/etb_pkg.sv */
`default_nettype none
package etb_pkg;

  // Width of a node index on the ports and in a stored link
  localparam int IDX_W = 10;

  typedef logic [IDX_W-1:0] etb_idx_t;

  // One word of the ancestor store
  typedef struct packed {
    logic     valid;
    etb_idx_t link;
  } etb_word_t;

  // Access request from the sequencer to the ancestor store
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } etb_mem_cmd_t;

endpackage
`default_nettype wire

/* hdl/etb_link_store.sv */
`default_nettype none
module etb_link_store
  import etb_pkg::*;
#(
  parameter int MAX_NODES = 1024,
  localparam int ADDR_W = $clog2(MAX_NODES)
) (
  input  wire logic              clk,
  input  wire etb_mem_cmd_t      mem_cmd,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire etb_word_t         wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output etb_word_t              rdata
);

  etb_word_t mem [MAX_NODES];
  etb_word_t rdata_r;

  // Write one word per cycle
  always_ff @(posedge clk) begin
    if (mem_cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    if (mem_cmd.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* hdl/etb_walk_ctrl.sv */
`default_nettype none
module etb_walk_ctrl
  import etb_pkg::*;
#(
  parameter int MAX_NODES = 1024,
  localparam int ADDR_W = $clog2(MAX_NODES)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_start_req,
  input  wire etb_idx_t          in_row,
  input  wire etb_idx_t          in_column,
  input  wire logic              out_busy,
  output logic                   emit_valid,
  output etb_idx_t               emit_child,
  output etb_idx_t               emit_parent,
  output etb_mem_cmd_t           mem_cmd,
  output logic [ADDR_W-1:0]      waddr,
  output etb_word_t              wdata,
  output logic [ADDR_W-1:0]      raddr,
  input  wire etb_word_t         rdata
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MAX_NODES - 1);

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              go_r, go_nxt;
  etb_idx_t          node_r, node_nxt;
  etb_idx_t          k_r, k_nxt;

  etb_idx_t cmp_a;
  etb_idx_t cmp_b;
  logic     cmp_lt;
  logic     in_range;

  // Share one less-than compare between the entry check and the walk step
  assign cmp_a    = (state_r == S_IDLE) ? in_column : rdata.link;
  assign cmp_b    = (state_r == S_IDLE) ? in_row : k_r;
  assign cmp_lt   = cmp_a < cmp_b;
  assign in_range = 32'(in_row) < MAX_NODES;

  assign in_ready    = (state_r == S_IDLE);
  assign emit_valid  = (state_r == S_EMIT);
  assign emit_child  = node_r;
  assign emit_parent = k_r;

  // Sequence clearing, link reads and compressed write-back
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    go_nxt      = go_r;
    node_nxt    = node_r;
    k_nxt       = k_r;
    mem_cmd     = '0;
    waddr       = ADDR_W'(node_r);
    wdata       = '{valid: 1'b1, link: k_r};
    raddr       = ADDR_W'(node_r);
    unique case (state_r)
      S_CLEAR: begin
        mem_cmd.wr_en = 1'b1;
        waddr         = clr_cnt_r;
        wdata         = '0;
        if (clr_cnt_r == CLR_LAST) begin
          clr_cnt_nxt = '0;
          state_nxt   = go_r ? S_RD : S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          node_nxt = in_column;
          k_nxt    = in_row;
          go_nxt   = in_range && cmp_lt;
          if (in_start_req) begin
            state_nxt = S_CLEAR;
          end else if (in_range && cmp_lt) begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        mem_cmd.rd_en = 1'b1;
        state_nxt     = S_EVAL;
      end
      S_EVAL: begin
        // point the visited node at the current row
        mem_cmd.wr_en = 1'b1;
        if (!rdata.valid) begin
          state_nxt = S_EMIT;
        end else if (cmp_lt) begin
          node_nxt      = rdata.link;
          mem_cmd.rd_en = 1'b1;
          raddr         = ADDR_W'(rdata.link);
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
      go_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      go_r      <= go_nxt;
    end
  end

  // Walk position and current row
  always_ff @(posedge clk) begin
    node_r <= node_nxt;
    k_r    <= k_nxt;
  end

endmodule
`default_nettype wire

/* hdl/elimination_tree_builder.sv */
`default_nettype none
// Elimination tree builder. Each input item is one lower-triangle entry
// (row, column) with a start flag; rows ascend within one matrix. An entry
// whose column is below its row walks up the stored ancestor links from the
// column node, pointing every visited node at the row. When the walk meets a
// node with no ancestor, one result item (child_node, parent_node = row) is
// produced; otherwise the item gives no result.
// Flow: the block takes one item at a time. A walk makes one read of the
// single-port-pair ancestor store per visited node and, when it finds a
// result, hands it to the output register from a separate emit state.
// Reset and start: after reset, and after every item with start_req set, a
// clearing pass writes all MAX_NODES store words, one per cycle, with
// in_ready low; the start item is then processed as usual.
// Stall: the result sits in an output register; the next item is taken while
// it waits, and a walk that finds a new result waits until the register frees.
module elimination_tree_builder
  import etb_pkg::*;
#(
  parameter int MAX_NODES = 1024
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic     in_start_req,
  input  wire etb_idx_t in_row,
  input  wire etb_idx_t in_column,
  output logic          out_valid,
  input  wire logic     out_ready,
  output etb_idx_t      out_child_node,
  output etb_idx_t      out_parent_node
);

  localparam int ADDR_W = $clog2(MAX_NODES);

  etb_mem_cmd_t      mem_cmd;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  etb_word_t         wdata;
  etb_word_t         rdata;

  logic     emit_valid;
  etb_idx_t emit_child;
  etb_idx_t emit_parent;
  logic     out_busy;
  logic     emit_fire;

  logic     out_valid_r;
  etb_idx_t out_child_r;
  etb_idx_t out_parent_r;

  etb_walk_ctrl #(
    .MAX_NODES(MAX_NODES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_start_req(in_start_req),
    .in_row      (in_row),
    .in_column   (in_column),
    .out_busy    (out_busy),
    .emit_valid  (emit_valid),
    .emit_child  (emit_child),
    .emit_parent (emit_parent),
    .mem_cmd     (mem_cmd),
    .waddr       (waddr),
    .wdata       (wdata),
    .raddr       (raddr),
    .rdata       (rdata)
  );

  etb_link_store #(
    .MAX_NODES(MAX_NODES)
  ) u_store (
    .clk    (clk),
    .mem_cmd(mem_cmd),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr  (raddr),
    .rdata  (rdata)
  );

  // Hold the result until the receiver takes it
  assign out_busy  = out_valid_r && !out_ready;
  assign emit_fire = emit_valid && !out_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_child_r  <= emit_child;
      out_parent_r <= emit_parent;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_child_node  = out_child_r;
  assign out_parent_node = out_parent_r;

endmodule
`default_nettype wire

/* hdl/etb_checker.sv */
`default_nettype none
`include "elimination_tree_builder_assert.svh"
module etb_checker
  import etb_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_ready,
  input wire logic     in_start_req,
  input wire etb_idx_t in_row,
  input wire etb_idx_t in_column,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire etb_idx_t out_child_node,
  input wire etb_idx_t out_parent_node
);

  // Stalled result holds its payload
  `ETB_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_child_node) && $stable(out_parent_node), "stalled result changed")

  // A tree parent always lies above its child
  `ETB_ASSERT_IMP(a_parent_above, out_valid, out_child_node < out_parent_node, "parent not above child")

  // A start item begins the clearing pass: no accept right after it
  `ETB_ASSERT_NXT(a_start_clears, in_valid && in_ready && in_start_req, !in_ready, "item taken during clearing")

  // Waiting input item holds its payload
  `ETB_ASSERT_NXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_start_req) && $stable(in_row) && $stable(in_column), "waiting input changed")

  // Reset starts the clearing pass with the output empty
  `ETB_ASSERT_RST(a_reset_state, !in_ready && !out_valid, "not cleared after reset")

endmodule

bind elimination_tree_builder etb_checker u_etb_checker (.*);
`default_nettype wire
